[sv/cfdfr_pkg.sv]
// Shared constants, phase codes and the parser-to-emitter command type.
package cfdfr_pkg;

  localparam int unsigned MaxPacketBytes = 1514;
  localparam int unsigned MinPacketBytes = 64;
  localparam int unsigned PktW = $clog2(MaxPacketBytes + 1);
  localparam int unsigned PadW = $clog2(MinPacketBytes + 1);

  localparam logic [31:0] ShbType   = 32'h0A0D0D0A;
  localparam logic [31:0] EpbType   = 32'h00000006;
  localparam logic [31:0] SpbType   = 32'h00000003;
  localparam logic [31:0] MagicUs   = 32'hA1B2C3D4;
  localparam logic [31:0] MagicUsSw = 32'hD4C3B2A1;
  localparam logic [31:0] MagicNs   = 32'hA1B23C4D;
  localparam logic [31:0] MagicNsSw = 32'h4D3CB2A1;
  localparam logic [31:0] BomSame   = 32'h1A2B3C4D;
  localparam logic [31:0] BomSwap   = 32'h4D3C2B1A;
  localparam logic [31:0] LenLimit  = 32'd65535;
  localparam logic [31:0] MinBlock  = 32'd12;

  localparam logic [3:0] PhMagic = 4'd0;
  localparam logic [3:0] PhChdr  = 4'd1;
  localparam logic [3:0] PhRec   = 4'd2;
  localparam logic [3:0] PhData  = 4'd3;
  localparam logic [3:0] PhType  = 4'd4;
  localparam logic [3:0] PhLen   = 4'd5;
  localparam logic [3:0] PhBom   = 4'd6;
  localparam logic [3:0] PhEpb   = 4'd7;
  localparam logic [3:0] PhSpb   = 4'd8;
  localparam logic [3:0] PhSkip  = 4'd9;
  localparam logic [3:0] PhIdle  = 4'd10;

  localparam logic [1:0] KindUnknown = 2'd0;
  localparam logic [1:0] KindClassic = 2'd1;
  localparam logic [1:0] KindBlock   = 2'd2;

  typedef struct packed {
    logic            byte_en;
    logic [7:0]      data;
    logic            blast;
    logic [PadW-1:0] pads;
    logic            attach;
    logic            bare;
    logic            aborted;
    logic            found;
  } cmd_t;

endpackage

[sv/cfdfr_parser.sv]
// Byte-wise capture file parser that turns each accepted word into an emit command.
module cfdfr_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         file_byte_i,
  input  logic               end_of_file_i,
  output cfdfr_pkg::cmd_t    cmd_o
);
  import cfdfr_pkg::*;

  logic [1:0]      kind_q, kind_d;
  logic            swap_q, swap_d;
  logic [3:0]      phase_q, phase_d;
  logic [4:0]      fcnt_q, fcnt_d;
  logic [31:0]     acc_q, acc_d;
  logic [31:0]     btype_q, btype_d;
  logic [31:0]     blen_q, blen_d;
  logic [15:0]     caplen_q, caplen_d;
  logic [PktW-1:0] emit_q, emit_d;
  logic [31:0]     skip_q, skip_d;
  logic [PktW-1:0] pkt_q, pkt_d;
  logic            any_q, any_d;

  logic [4:0]      cnt_inc;
  logic [31:0]     acc_t, fix_v, cap_v;
  logic            swap_new;
  logic            do_skip, do_start;
  logic [31:0]     skip_val, start_cap, start_after;
  logic            open;
  cmd_t            cmd;

  function automatic logic [31:0] order_fix(input logic [31:0] v, input logic sw);
    order_fix = sw ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
  endfunction

  function automatic logic [31:0] take(input logic [31:0] acc, input logic [4:0] cnt,
                                       input logic [7:0] b, input logic [4:0] lo);
    logic [4:0] rel;
    rel  = cnt - lo;
    take = acc;
    if (cnt >= lo && cnt < lo + 5'd4) begin
      take = acc | ({24'd0, b} << {rel[1:0], 3'b000});
    end
  endfunction

  assign cnt_inc = fcnt_q + 5'd1;

  always_comb begin
    kind_d = kind_q; swap_d = swap_q; phase_d = phase_q; fcnt_d = fcnt_q;
    acc_d = acc_q; btype_d = btype_q; blen_d = blen_q; caplen_d = caplen_q;
    emit_d = emit_q; skip_d = skip_q; pkt_d = pkt_q; any_d = any_q;
    acc_t = acc_q; fix_v = '0; cap_v = '0; swap_new = swap_q;
    do_skip = 1'b0; skip_val = '0; do_start = 1'b0; start_cap = '0; start_after = '0;
    cmd = '0;
    cmd.data = file_byte_i;
    case (phase_q)
      PhMagic: begin
        acc_t = take(acc_q, fcnt_q, file_byte_i, 5'd0);
        acc_d = acc_t; fcnt_d = cnt_inc;
        if (cnt_inc == 5'd4) begin
          if (acc_t == MagicUs || acc_t == MagicNs || acc_t == MagicUsSw ||
              acc_t == MagicNsSw) begin
            kind_d = KindClassic;
            swap_d = (acc_t == MagicUsSw || acc_t == MagicNsSw);
            phase_d = PhChdr; fcnt_d = '0; acc_d = '0;
          end else if (acc_t == ShbType) begin
            kind_d = KindBlock; btype_d = acc_t;
            phase_d = PhLen; fcnt_d = '0; acc_d = '0;
          end else begin
            phase_d = PhIdle;
          end
        end
      end
      PhChdr: begin
        fcnt_d = cnt_inc;
        if (cnt_inc == 5'd20) begin
          phase_d = PhRec; fcnt_d = '0; acc_d = '0;
        end
      end
      PhRec: begin
        acc_t = take(acc_q, fcnt_q, file_byte_i, 5'd8);
        acc_d = acc_t; fcnt_d = cnt_inc;
        if (cnt_inc == 5'd16) begin
          cap_v = order_fix(acc_t, swap_q);
          if (cap_v == '0 || cap_v > LenLimit) phase_d = PhIdle;
          else begin
            do_start = 1'b1; start_cap = cap_v; start_after = '0;
          end
        end
      end
      PhData: begin
        if (pkt_q < emit_q) begin
          pkt_d = pkt_q + PktW'(1);
          cmd.byte_en = 1'b1;
          if (pkt_d >= emit_q) begin
            any_d = 1'b1;
            if (emit_q >= PktW'(MinPacketBytes)) cmd.blast = 1'b1;
            else cmd.pads = PadW'(MinPacketBytes) - PadW'(emit_q);
          end
        end
        caplen_d = caplen_q - 16'd1;
        if (caplen_q == 16'd1) begin
          if (kind_q == KindClassic) begin
            phase_d = PhRec; fcnt_d = '0; acc_d = '0;
          end else begin
            do_skip = 1'b1; skip_val = skip_q;
          end
        end
      end
      PhType: begin
        acc_t = take(acc_q, fcnt_q, file_byte_i, 5'd0);
        acc_d = acc_t; fcnt_d = cnt_inc;
        if (cnt_inc == 5'd4) begin
          btype_d = acc_t;
          phase_d = PhLen; fcnt_d = '0; acc_d = '0;
        end
      end
      PhLen: begin
        acc_t = take(acc_q, fcnt_q, file_byte_i, 5'd0);
        acc_d = acc_t; fcnt_d = cnt_inc;
        if (cnt_inc == 5'd4) begin
          if (btype_q == ShbType) begin
            blen_d = acc_t;
            phase_d = PhBom; fcnt_d = '0; acc_d = '0;
          end else begin
            blen_d = order_fix(acc_t, swap_q);
            fix_v = order_fix(btype_q, swap_q);
            if (blen_d < MinBlock) phase_d = PhIdle;
            else if (fix_v == EpbType) begin
              phase_d = PhEpb; fcnt_d = '0; acc_d = '0;
            end else if (fix_v == SpbType) begin
              phase_d = PhSpb; fcnt_d = '0; acc_d = '0;
            end else begin
              do_skip = 1'b1; skip_val = blen_d - 32'd8;
            end
          end
        end
      end
      PhBom: begin
        acc_t = take(acc_q, fcnt_q, file_byte_i, 5'd0);
        acc_d = acc_t; fcnt_d = cnt_inc;
        if (cnt_inc == 5'd4) begin
          if (acc_t == BomSame) swap_new = 1'b0;
          else if (acc_t == BomSwap) swap_new = 1'b1;
          swap_d = swap_new;
          fix_v = order_fix(blen_q, swap_new);
          blen_d = fix_v;
          do_skip = 1'b1;
          skip_val = (fix_v > 32'd12) ? fix_v - 32'd12 : '0;
        end
      end
      PhEpb: begin
        acc_t = take(acc_q, fcnt_q, file_byte_i, 5'd12);
        acc_d = acc_t; fcnt_d = cnt_inc;
        if (cnt_inc == 5'd20) begin
          cap_v = order_fix(acc_t, swap_q);
          if (cap_v == '0 || cap_v > LenLimit) begin
            do_skip = 1'b1;
            skip_val = (blen_q > 32'd28) ? blen_q - 32'd28 : '0;
          end else begin
            do_start = 1'b1; start_cap = cap_v;
            start_after = (blen_q > 32'd28 + cap_v) ? blen_q - 32'd28 - cap_v : '0;
          end
        end
      end
      PhSpb: begin
        acc_t = take(acc_q, fcnt_q, file_byte_i, 5'd0);
        acc_d = acc_t; fcnt_d = cnt_inc;
        if (cnt_inc == 5'd4) begin
          fix_v = order_fix(acc_t, swap_q);
          cap_v = blen_q - 32'd16;
          if (cap_v > fix_v) cap_v = fix_v;
          if (cap_v == '0 || cap_v > LenLimit) begin
            do_skip = 1'b1; skip_val = blen_q - 32'd12;
          end else begin
            do_start = 1'b1; start_cap = cap_v;
            start_after = (blen_q > 32'd12 + cap_v) ? blen_q - 32'd12 - cap_v : '0;
          end
        end
      end
      PhSkip: begin
        skip_d = skip_q - 32'd1;
        if (skip_q == 32'd1) begin
          phase_d = PhType; fcnt_d = '0; acc_d = '0;
        end
      end
      default: begin
      end
    endcase

    if (do_start) begin
      caplen_d = start_cap[15:0];
      emit_d = (start_cap > 32'(MaxPacketBytes)) ? PktW'(MaxPacketBytes)
                                                 : start_cap[PktW-1:0];
      pkt_d = '0;
      skip_d = start_after;
      phase_d = PhData;
    end
    if (do_skip) begin
      skip_d = skip_val;
      if (skip_val == '0) begin
        phase_d = PhType; fcnt_d = '0; acc_d = '0;
      end else begin
        phase_d = PhSkip;
      end
    end

    open = (phase_d == PhData) && (pkt_d != '0) && (pkt_d < emit_d);
    cmd.attach  = end_of_file_i && cmd.byte_en && !open;
    cmd.bare    = end_of_file_i && !(cmd.byte_en && !open);
    cmd.aborted = open;
    cmd.found   = any_d;

    if (end_of_file_i) begin
      kind_d = KindUnknown; swap_d = 1'b0; phase_d = PhMagic; fcnt_d = '0;
      acc_d = '0; btype_d = '0; blen_d = '0; caplen_d = '0; emit_d = '0;
      skip_d = '0; pkt_d = '0; any_d = 1'b0;
    end
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KindUnknown; swap_q <= 1'b0; phase_q <= PhMagic; fcnt_q <= '0;
      acc_q <= '0; btype_q <= '0; blen_q <= '0; caplen_q <= '0; emit_q <= '0;
      skip_q <= '0; pkt_q <= '0; any_q <= 1'b0;
    end else if (accept_i) begin
      kind_q <= kind_d; swap_q <= swap_d; phase_q <= phase_d; fcnt_q <= fcnt_d;
      acc_q <= acc_d; btype_q <= btype_d; blen_q <= blen_d; caplen_q <= caplen_d;
      emit_q <= emit_d; skip_q <= skip_d; pkt_q <= pkt_d; any_q <= any_d;
    end
  end

endmodule

[sv/cfdfr_emitter.sv]
// Holds one emit command and plays it out as result words into the output register.
module cfdfr_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  cfdfr_pkg::cmd_t cmd_i,
  output logic            can_load_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            byte_valid_o,
  output logic [7:0]      data_o,
  output logic            is_pad_o,
  output logic            packet_last_o,
  output logic            aborted_o,
  output logic            file_end_o,
  output logic            found_packets_o
);
  import cfdfr_pkg::*;

  logic            bpend_q, bpend_d;
  logic            bare_q, bare_d;
  logic [PadW-1:0] pads_q, pads_d;
  logic [7:0]      cdata_q;
  logic            blast_q, attach_q, ab_q, fp_q;
  logic            ov_q, ov_d;
  logic            obv_q, obv_d, opad_q, opad_d, olast_q, olast_d;
  logic            oab_q, oab_d, ofe_q, ofe_d, ofp_q, ofp_d;
  logic [7:0]      odata_q, odata_d;
  logic            ofree, busy, single;

  assign ofree  = !ov_q || out_ready_i;
  assign busy   = bpend_q || bare_q || (pads_q != '0);
  assign single = (32'(bpend_q) + 32'(bare_q) + 32'(pads_q)) == 32'd1;
  assign can_load_o = !busy || (single && ofree);

  always_comb begin
    bpend_d = bpend_q; bare_d = bare_q; pads_d = pads_q;
    ov_d = ov_q && !out_ready_i;
    obv_d = obv_q; odata_d = odata_q; opad_d = opad_q; olast_d = olast_q;
    oab_d = oab_q; ofe_d = ofe_q; ofp_d = ofp_q;
    if (ofree && busy) begin
      ov_d = 1'b1; oab_d = 1'b0;
      if (bpend_q) begin
        bpend_d = 1'b0;
        obv_d = 1'b1; odata_d = cdata_q; opad_d = 1'b0;
        olast_d = blast_q && (pads_q == '0);
        ofe_d = attach_q && (pads_q == '0);
        ofp_d = ofe_d && fp_q;
      end else if (pads_q != '0) begin
        pads_d = pads_q - PadW'(1);
        obv_d = 1'b1; odata_d = '0; opad_d = 1'b1;
        olast_d = (pads_q == PadW'(1));
        ofe_d = attach_q && olast_d;
        ofp_d = ofe_d && fp_q;
      end else begin
        bare_d = 1'b0;
        obv_d = 1'b0; odata_d = '0; opad_d = 1'b0; olast_d = 1'b0;
        oab_d = ab_q; ofe_d = 1'b1; ofp_d = fp_q;
      end
    end
    if (load_i) begin
      bpend_d = cmd_i.byte_en; bare_d = cmd_i.bare; pads_d = cmd_i.pads;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpend_q <= 1'b0; bare_q <= 1'b0; pads_q <= '0; ov_q <= 1'b0;
    end else begin
      bpend_q <= bpend_d; bare_q <= bare_d; pads_q <= pads_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cdata_q <= cmd_i.data; blast_q <= cmd_i.blast; attach_q <= cmd_i.attach;
      ab_q <= cmd_i.aborted; fp_q <= cmd_i.found;
    end
    obv_q <= obv_d; odata_q <= odata_d; opad_q <= opad_d; olast_q <= olast_d;
    oab_q <= oab_d; ofe_q <= ofe_d; ofp_q <= ofp_d;
  end

  assign out_valid_o     = ov_q;
  assign byte_valid_o    = obv_q;
  assign data_o          = odata_q;
  assign is_pad_o        = opad_q;
  assign packet_last_o   = olast_q;
  assign aborted_o       = oab_q;
  assign file_end_o      = ofe_q;
  assign found_packets_o = ofp_q;

endmodule

[sv/capture_file_packet_deframer_core.sv]
// Top level of the capture file packet deframer.
//
// The input channel takes one word per handshake: a file byte and an end-of-file
// flag marking the last byte of the file. The output channel gives one word per
// handshake: a packet byte or zero pad byte with its last-of-packet mark, or a
// bare end-of-file word that can carry the aborted flag.
// A word that yields one result is accepted every cycle while the output is not
// stalled; its result passes through the command slot into the output register.
// A short packet's final byte expands into up to 64 results, one per cycle from
// the output register while the receiver takes them, and the input is held off
// until all but the last of them have left.
// End of file adds at most one extra result and returns the parser to its
// starting state for the next file.
// Reset clears the parser to await the file magic and empties the output side.
// When the receiver stalls, the output register holds its word, the pending
// command waits behind it, and input ready drops once that command slot is busy.
module capture_file_packet_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] file_byte_i,
  input  logic       end_of_file_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       byte_valid_o,
  output logic [7:0] data_o,
  output logic       is_pad_o,
  output logic       packet_last_o,
  output logic       aborted_o,
  output logic       file_end_o,
  output logic       found_packets_o
);
  import cfdfr_pkg::*;

  cmd_t cmd;
  logic accept, can_load;

  assign in_ready_o = can_load;
  assign accept = in_valid_i && can_load;

  cfdfr_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .file_byte_i   (file_byte_i),
    .end_of_file_i (end_of_file_i),
    .cmd_o         (cmd)
  );

  cfdfr_emitter u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept),
    .cmd_i           (cmd),
    .can_load_o      (can_load),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .byte_valid_o    (byte_valid_o),
    .data_o          (data_o),
    .is_pad_o        (is_pad_o),
    .packet_last_o   (packet_last_o),
    .aborted_o       (aborted_o),
    .file_end_o      (file_end_o),
    .found_packets_o (found_packets_o)
  );

endmodule

[sv/cfdfr_checker.sv]
// Port-level checks on the deframer output words and their binding to the top level.
module cfdfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       byte_valid_i,
  input logic [7:0] data_i,
  input logic       is_pad_i,
  input logic       aborted_i,
  input logic       file_end_i,
  input logic       found_packets_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(data_i) && $stable(file_end_i))
    else $error("Output word changed while stalled.");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_pad_i |-> byte_valid_i && data_i == 8'd0)
    else $error("Pad word is not a zero data byte.");

  a_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && aborted_i |-> file_end_i && !byte_valid_i)
    else $error("Aborted word is not a bare end-of-file word.");

  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_packets_i |-> file_end_i)
    else $error("Found flag set outside an end-of-file word.");

endmodule

bind capture_file_packet_deframer_core cfdfr_checker u_cfdfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .byte_valid_i    (byte_valid_o),
  .data_i          (data_o),
  .is_pad_i        (is_pad_o),
  .aborted_i       (aborted_o),
  .file_end_i      (file_end_o),
  .found_packets_i (found_packets_o)
);
